// ===== sv/kct_pkg.sv =====
package kct_pkg;

   // table geometry
   localparam int ENTRIES  = 32;
   localparam int TAG_BITS = 16;

   // port widths
   localparam int TAG_PORT_BITS = 16;
   localparam int AMOUNT_BITS   = 32;
   localparam int COUNT_BITS    = 31;
   localparam int STATUS_BITS   = 3;

   // derived widths
   localparam int KEY_BITS = (TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS;
   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      CMD_ADD      = 2'd0,
      CMD_REMOVE   = 2'd1,
      CMD_OVERRIDE = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_UPDATED    = 3'd0,
      ST_INSERTED   = 3'd1,
      ST_REMOVED    = 3'd2,
      ST_OVER       = 3'd3,
      ST_BAD_TAG    = 3'd4,
      ST_BAD_AMOUNT = 3'd5,
      ST_NOT_FOUND  = 3'd6,
      ST_FULL       = 3'd7
   } status_type;

   // classified request, as queued between front and back
   typedef struct packed {
      cmd_type               cmd;
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] amount;
      logic                  tag_bad;
      logic                  amount_bad;
   } op_type;

   // queue head seen by the back end
   typedef struct packed {
      logic   valid;
      op_type op;
   } head_type;

endpackage

// ===== sv/kct_ram.sv =====
module kct_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 16,
     parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (input  logic             clock,
    input  logic             wr_en,
    input  logic [ABITS-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [ABITS-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/kct_front.sv =====
module kct_front
   import kct_pkg::*;
   (input  logic                     clock,
    input  logic                     reset,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               req_command,
    input  logic [TAG_PORT_BITS-1:0] req_tag,
    input  logic [AMOUNT_BITS-1:0]   req_amount,
    output head_type                 head,
    input  logic                     pop);

   op_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   op_type               op_in;
   logic                 accept;
   logic                 push;
   logic                 do_pop;

   // classify the incoming beat
   always_comb begin
      op_in.cmd        = cmd_type'(req_command);
      op_in.key        = req_tag[KEY_BITS-1:0];
      op_in.amount     = req_amount[COUNT_BITS-1:0];
      op_in.tag_bad    = (req_tag[KEY_BITS-1:0] == '0);
      op_in.amount_bad = (req_amount == '0) || req_amount[AMOUNT_BITS-1];
   end

   assign busy   = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign accept = start && !busy;
   // unused command code is dropped here, it produces no result
   assign push   = accept && (cmd_type'(req_command) != CMD_UNUSED);
   assign do_pop = pop && (count_ff != '0);

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= op_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.op    = slot_ff[rd_ptr_ff];

   // queue never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("request queue overfilled");

endmodule

// ===== sv/kct_back.sv =====
module kct_back
   import kct_pkg::*;
   (input  logic                    clock,
    input  logic                    reset,
    input  head_type                head,
    output logic                    pop,
    output logic                    rsp_strobe,
    output logic [STATUS_BITS-1:0]  rsp_status,
    output logic [COUNT_BITS-1:0]   rsp_new_count);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_READ   = 4'b0100,
      S_EXEC   = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   op_type                op_ff;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff [ENTRIES];
   logic                  hit_ff, free_ff;
   logic [IDX_BITS-1:0]   hit_idx_ff, free_idx_ff;
   logic                  hit_in, free_in;
   logic [IDX_BITS-1:0]   hit_idx_in, free_idx_in;
   logic                  rsp_strobe_ff;
   status_type            rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [COUNT_BITS-1:0] held;
   logic [COUNT_BITS:0]   sum;
   logic                  ram_we;
   logic [IDX_BITS-1:0]   ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata;
   logic [COUNT_BITS-1:0] ram_rdata;
   logic                  key_we;
   logic                  exec;

   assign pop  = (state_ff == S_IDLE) && head.valid;
   assign exec = (state_ff == S_EXEC);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (head.valid) begin state_in = S_SEARCH; end
         S_SEARCH: state_in = S_READ;
         S_READ:   state_in = S_EXEC;
         S_EXEC:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // parallel tag compare, lowest matching and lowest free slot
   always_comb begin
      hit_in      = 1'b0;
      free_in     = 1'b0;
      hit_idx_in  = '0;
      free_idx_in = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (key_ff[i] == op_ff.key)) begin
            hit_in     = 1'b1;
            hit_idx_in = IDX_BITS'(i);
         end
         if (!valid_ff[i]) begin
            free_in     = 1'b1;
            free_idx_in = IDX_BITS'(i);
         end
      end
   end

   // count storage, read at the matching slot
   kct_ram #(.WIDTH(COUNT_BITS), .DEPTH(ENTRIES), .ABITS(IDX_BITS)) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (hit_idx_ff),
      .rd_data (ram_rdata));

   assign held = hit_ff ? ram_rdata : '0;
   assign sum  = {1'b0, held} + {1'b0, op_ff.amount};

   // execute the command against the table
   always_comb begin
      valid_in      = valid_ff;
      ram_we        = 1'b0;
      ram_waddr     = hit_idx_ff;
      ram_wdata     = op_ff.amount;
      key_we        = 1'b0;
      rsp_status_in = ST_UPDATED;
      rsp_count_in  = '0;
      if (op_ff.tag_bad) begin
         rsp_status_in = ST_BAD_TAG;
      end else if (op_ff.amount_bad) begin
         rsp_status_in = ST_BAD_AMOUNT;
         rsp_count_in  = held;
      end else if (op_ff.cmd == CMD_REMOVE) begin
         if (!hit_ff) begin
            rsp_status_in = ST_NOT_FOUND;
         end else if (held <= op_ff.amount) begin
            valid_in[hit_idx_ff] = 1'b0;
            rsp_status_in        = (held == op_ff.amount) ? ST_REMOVED : ST_OVER;
         end else begin
            ram_we        = 1'b1;
            ram_wdata     = held - op_ff.amount;
            rsp_status_in = ST_UPDATED;
            rsp_count_in  = held - op_ff.amount;
         end
      end else if (hit_ff) begin
         ram_we = 1'b1;
         if (op_ff.cmd == CMD_ADD) begin
            ram_wdata = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
         end else begin
            ram_wdata = op_ff.amount;
         end
         rsp_status_in = ST_UPDATED;
         rsp_count_in  = ram_wdata;
      end else if (free_ff) begin
         ram_we               = 1'b1;
         ram_waddr            = free_idx_ff;
         ram_wdata            = op_ff.amount;
         key_we               = 1'b1;
         valid_in[free_idx_ff] = 1'b1;
         rsp_status_in        = ST_INSERTED;
         rsp_count_in         = op_ff.amount;
      end else begin
         rsp_status_in = ST_FULL;
      end
      if (!exec) begin
         valid_in = valid_ff;
         ram_we   = 1'b0;
         key_we   = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= exec;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff <= head.op;
      end
      if (state_ff == S_SEARCH) begin
         hit_ff      <= hit_in;
         hit_idx_ff  <= hit_idx_in;
         free_ff     <= free_in;
         free_idx_ff <= free_idx_in;
      end
      if (key_we) begin
         key_ff[free_idx_ff] <= op_ff.key;
      end
      if (exec) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_new_count = rsp_count_ff;

   // a result beat only comes right after an execute step
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == S_EXEC))
      else $error("result beat without execute step");

   // an insert occupies exactly one more slot
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_status_ff == ST_INSERTED)) |->
         ($countones(valid_ff) == $past($countones(valid_ff)) + 1))
      else $error("insert did not claim one slot");

   // a removal frees exactly one slot
   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && ((rsp_status_ff == ST_REMOVED) || (rsp_status_ff == ST_OVER))) |->
         ($countones(valid_ff) + 1 == $past($countones(valid_ff))))
      else $error("removal did not free one slot");

   // the table only changes in the execute step
   a_table_quiet: assert property (@(posedge clock) disable iff (reset)
      !$past(exec) |-> $stable(valid_ff))
      else $error("slot occupancy changed outside execute");

endmodule

// ===== sv/keyed_counter_table_unit.sv =====
// Keyed counter table: up to ENTRIES tag/count pairs updated by add, remove and override
// commands. A command beat is taken when start is high and busy is low; command code 3 is
// dropped and yields no result, every other beat yields exactly one result beat, marked by
// rsp_strobe for a single cycle, in request order. The receiver cannot stall the result
// channel. Each command passes through the execution engine in order (queue pop, parallel tag
// compare with lowest-slot select, count memory read, update and result) and the engine
// finishes one command before it pops the next; a 2-deep request queue lets start be taken
// back to back until it fills, after which busy stays high until the engine frees a place.
// The table is empty after reset and needs no clearing pass.
module keyed_counter_table_unit
   import kct_pkg::*;
   (input  logic                     clock,
    input  logic                     reset,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               req_command,
    input  logic [TAG_PORT_BITS-1:0] req_tag,
    input  logic [AMOUNT_BITS-1:0]   req_amount,
    output logic                     rsp_strobe,
    output logic [STATUS_BITS-1:0]   rsp_status,
    output logic [COUNT_BITS-1:0]    rsp_new_count);

   head_type head;
   logic     pop;

   // accept and classify, queue
   kct_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_tag     (req_tag),
      .req_amount  (req_amount),
      .head        (head),
      .pop         (pop));

   // table lookup and update
   kct_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_new_count (rsp_new_count));

endmodule

// ===== sim/tb_keyed_counter_table_unit.sv =====
`timescale 1ns / 100ps

module tb_keyed_counter_table_unit;
   import kct_pkg::*;

   localparam int RANDOM_BEATS = 1200;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 16;
   localparam int POOL_MAX     = 48;

   // mirror of the tag/count table plus the queue of replies it predicts
   class tag_count_scoreboard;
      logic                  slot_used  [ENTRIES];
      logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
      logic [COUNT_BITS-1:0] slot_total [ENTRIES];
      status_type            status_q[$];
      logic [COUNT_BITS-1:0] count_q[$];
      int unsigned           mismatches;

      function new();
         for (int i = 0; i < ENTRIES; i++) begin
            slot_used[i] = 1'b0;
         end
         mismatches = 0;
      endfunction

      function int pending();
         return status_q.size();
      endfunction

      function void push_reply(status_type st, logic [COUNT_BITS-1:0] cnt);
         status_q.push_back(st);
         count_q.push_back(cnt);
      endfunction

      function int find_key(logic [KEY_BITS-1:0] k);
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && slot_key[i] == k) return i;
         end
         return -1;
      endfunction

      // lowest numbered empty slot, -1 when the table is full
      function int find_free();
         for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_used[i]) return i;
         end
         return -1;
      endfunction

      // apply one accepted command beat to the mirror and queue its reply
      function void note_request(cmd_type cmd, logic [TAG_PORT_BITS-1:0] tag,
                                 logic [AMOUNT_BITS-1:0] amount);
         logic [KEY_BITS-1:0]   k;
         logic                  positive;
         logic [COUNT_BITS-1:0] amt;
         logic [COUNT_BITS:0]   sum;
         int                    slot;
         k        = tag[KEY_BITS-1:0];
         positive = (amount != '0) && !amount[AMOUNT_BITS-1];
         amt      = amount[COUNT_BITS-1:0];
         if (cmd == CMD_UNUSED) return;
         if (k == '0) begin
            push_reply(ST_BAD_TAG, '0);
            return;
         end
         slot = find_key(k);
         if (!positive) begin
            push_reply(ST_BAD_AMOUNT, (slot >= 0) ? slot_total[slot] : '0);
            return;
         end
         // remove lowers the count or frees the entry
         if (cmd == CMD_REMOVE) begin
            if (slot < 0) begin
               push_reply(ST_NOT_FOUND, '0);
            end else if (slot_total[slot] <= amt) begin
               push_reply((slot_total[slot] == amt) ? ST_REMOVED : ST_OVER, '0);
               slot_used[slot] = 1'b0;
            end else begin
               slot_total[slot] = slot_total[slot] - amt;
               push_reply(ST_UPDATED, slot_total[slot]);
            end
            return;
         end
         // add saturates, override replaces
         if (slot >= 0) begin
            if (cmd == CMD_ADD) begin
               sum = {1'b0, slot_total[slot]} + {1'b0, amt};
               slot_total[slot] = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
            end else begin
               slot_total[slot] = amt;
            end
            push_reply(ST_UPDATED, slot_total[slot]);
            return;
         end
         // insert into the lowest free slot
         slot = find_free();
         if (slot < 0) begin
            push_reply(ST_FULL, '0);
         end else begin
            slot_used[slot]  = 1'b1;
            slot_key[slot]   = k;
            slot_total[slot] = amt;
            push_reply(ST_INSERTED, amt);
         end
      endfunction

      // compare one result beat with the oldest predicted reply
      function void check_reply(logic [STATUS_BITS-1:0] st, logic [COUNT_BITS-1:0] cnt);
         status_type            exp_st;
         logic [COUNT_BITS-1:0] exp_cnt;
         if (status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: status %0d count %0d", st, cnt);
            return;
         end
         exp_st  = status_q.pop_front();
         exp_cnt = count_q.pop_front();
         if (st !== exp_st) begin
            mismatches++;
            if (mismatches <= 10)
               $display("status mismatch: expected %0d actual %0d", exp_st, st);
         end
         if (cnt !== exp_cnt) begin
            mismatches++;
            if (mismatches <= 10)
               $display("new_count mismatch: expected %0d actual %0d", exp_cnt, cnt);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_command;
   logic [TAG_PORT_BITS-1:0] req_tag;
   logic [AMOUNT_BITS-1:0]   req_amount;
   logic                     rsp_strobe;
   logic [STATUS_BITS-1:0]   rsp_status;
   logic [COUNT_BITS-1:0]    rsp_new_count;

   tag_count_scoreboard      sb = new();
   logic                     no_idle;
   logic [TAG_PORT_BITS-1:0] tag_pool [POOL_MAX];
   int                       pool_size;
   int                       phase_mode;
   int                       counted;

   keyed_counter_table_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_tag       (req_tag),
      .req_amount    (req_amount),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_new_count (rsp_new_count));

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_reply(rsp_status, rsp_new_count);
   end

   // hang guard
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("keyed_counter_table_unit regression: fail");
      $finish;
   end

   // one command beat, with an optional idle gap in front
   task automatic send_beat(input cmd_type cmd, input logic [TAG_PORT_BITS-1:0] tag,
                            input logic [AMOUNT_BITS-1:0] amount);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_tag     <= tag;
      req_amount  <= amount;
      do @(posedge clock); while (busy);
      sb.note_request(cmd, tag, amount);
   endtask

   // random beat drawn from the current tag pool and phase mix
   task automatic send_random_beat();
      int                       r;
      cmd_type                  cmd;
      logic [TAG_PORT_BITS-1:0] tag;
      logic [AMOUNT_BITS-1:0]   amount;
      // command mix depends on whether the phase fills or drains the table
      r = $urandom_range(0, 99);
      if (r < 3) cmd = CMD_UNUSED;
      else if (phase_mode == 0) cmd = (r < 50) ? CMD_ADD : (r < 82) ? CMD_OVERRIDE : CMD_REMOVE;
      else if (phase_mode == 1) cmd = (r < 25) ? CMD_ADD : (r < 38) ? CMD_OVERRIDE : CMD_REMOVE;
      else cmd = (r < 36) ? CMD_ADD : (r < 66) ? CMD_OVERRIDE : CMD_REMOVE;
      // tag mostly from the pool so entries get revisited
      r = $urandom_range(0, 99);
      if (r < 3) tag = '0;
      else if (r < 6) tag = TAG_PORT_BITS'($urandom_range(0, 65535));
      else tag = tag_pool[$urandom_range(0, pool_size - 1)];
      // amount: small values hit exact removes, large ones saturate
      r = $urandom_range(0, 99);
      if (r < 2) amount = '0;
      else if (r < 3) amount = 32'h8000_0000;
      else if (r < 6) amount = $urandom() | 32'h8000_0000;
      else if (r < 75) amount = $urandom_range(1, 20);
      else if (r < 85) amount = 32'h7FFF_FF00 + $urandom_range(0, 255);
      else amount = $urandom() & 32'h7FFF_FFFF;
      send_beat(cmd, tag, amount);
      if (cmd != CMD_UNUSED) counted++;
   endtask

   initial begin
      int phase_len;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_command <= '0;
      req_tag     <= '0;
      req_amount  <= '0;
      no_idle     = 1'b0;
      counted     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: bad tags, bad amounts, saturation, each remove outcome
      send_beat(CMD_ADD,      16'h0000, 32'd5);
      send_beat(CMD_OVERRIDE, 16'h0000, 32'hFFFF_FFFF);
      send_beat(CMD_REMOVE,   16'hFFFF, 32'd3);
      send_beat(CMD_ADD,      16'hFFFF, 32'h7FFF_FFFF);
      send_beat(CMD_ADD,      16'hFFFF, 32'd1);
      send_beat(CMD_ADD,      16'hFFFF, 32'd0);
      send_beat(CMD_REMOVE,   16'hFFFF, 32'h8000_0000);
      send_beat(CMD_OVERRIDE, 16'hFFFF, 32'd10);
      send_beat(CMD_REMOVE,   16'hFFFF, 32'd4);
      send_beat(CMD_REMOVE,   16'hFFFF, 32'd6);
      send_beat(CMD_OVERRIDE, 16'h0001, 32'd7);
      send_beat(CMD_UNUSED,   16'h0001, 32'd7);
      send_beat(CMD_REMOVE,   16'h0001, 32'd100);
      send_beat(CMD_ADD,      16'h8000, 32'hFFFF_FFFB);
      send_beat(CMD_OVERRIDE, 16'h5555, 32'h7FFF_FFFF);
      send_beat(CMD_ADD,      16'hAAAA, 32'd1);
      send_beat(CMD_REMOVE,   16'h5555, 32'h7FFF_FFFE);
      send_beat(CMD_REMOVE,   16'h5555, 32'd1);
      send_beat(CMD_REMOVE,   16'hAAAA, 32'd1);

      // random phases: pools wider than the table force the full case
      while (counted < RANDOM_BEATS) begin
         pool_size  = $urandom_range(4, POOL_MAX);
         phase_mode = $urandom_range(0, 2);
         no_idle    = ($urandom_range(0, 3) == 0);
         phase_len  = $urandom_range(40, 120);
         for (int i = 0; i < POOL_MAX; i++) begin
            tag_pool[i] = TAG_PORT_BITS'($urandom_range(1, 65535));
         end
         repeat (phase_len) send_random_beat();
      end
      start <= 1'b0;

      // drain outstanding replies, then watch for strays
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("keyed_counter_table_unit regression: pass");
      else
         $display("keyed_counter_table_unit regression: fail");
      $finish;
   end

endmodule
